### hw/rtl/iptr_pkg.sv
// iptr_pkg: constants, register indexes and reset values shared by the
// incremental PI temperature regulator. No dependencies.

package iptr_pkg;

    // field widths
    localparam int TEMP_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = TEMP_W + 1;
    localparam int PROD_W   = GAIN_W + ERR_W;
    localparam int DRIVE_W  = 16;
    localparam int DUTY_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // gain products are Q11.22, drive is 1/4096 V
    localparam int PRODUCT_SHIFT = 10;
    localparam int TERM_W        = PROD_W - PRODUCT_SHIFT;
    localparam int RAW_W         = TERM_W + 2;

    // drive limit (12 V in 1/4096 V)
    localparam logic [DRIVE_W-1:0] DRIVE_MAX = 16'd49152;

    // duty = floor(4*drive/3) by reciprocal: x*ceil(2^19/3) >> 19, exact for x < 2^19
    localparam int DUTY_X_W  = DRIVE_W + 2;
    localparam int DUTY_SHIFT = 19;
    localparam logic [DUTY_X_W-1:0] DUTY_RECIP = 18'd174763;
    localparam int DUTY_PROD_W = 2 * DUTY_X_W;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT  = 2'd0,
        CFG_GAIN_CUR  = 2'd1,
        CFG_GAIN_PREV = 2'd2
    } cfg_index_t;

    // register reset values
    localparam logic signed [TEMP_W-1:0] SETPOINT_RESET  = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_CUR_RESET  = 16'sd8402;
    localparam logic signed [GAIN_W-1:0] GAIN_PREV_RESET = -16'sd8374;

    // input mode codes
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

endpackage

### hw/rtl/incremental_pi_temperature_regulator.sv
// Incremental PI temperature regulator top level: three-stage stream pipeline
// with history registers and configuration registers. Depends on iptr_pkg.
//
// Usage:
//   Input stream s_*: s_tdata[15:0] is the measured temperature (signed Q8.8),
//   s_tuser[0] is the mode (0 = sample, 1 = clear history). Result stream m_*:
//   m_tdata holds drive voltage (1/4096 V) and duty cycle (1/65536), m_tuser[0]
//   flags that the raw drive was clamped. Configuration is a plain write port
//   (cfg_wr_en, cfg_index, cfg_data): setpoint, current and previous error gain;
//   write it only while no request is in flight.
//   A request passes the input, middle and output registers in order. Throughput:
//   one request per cycle while m_tready is high, since error, both gain products,
//   the sum and the clamp with the feedback to the history registers settle
//   combinationally into the middle stage; the duty divide by 3 follows in its own
//   stage. Every stage holds its request while the next is full, so when m_tready
//   is low the block still takes up to three more requests before s_tready drops.
//   Reset (aresetn low, synchronous) empties the pipeline, zeroes the history
//   and loads the default setpoint and gains.

module incremental_pi_temperature_regulator
    import iptr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] measured_temp
    input  logic [0:0]            s_tuser,   // [0] mode
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // [15:0] drive_voltage, [32:16] duty_cycle
    output logic [0:0]            m_tuser,   // [0] clamped
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic signed [TEMP_W-1:0] setpoint_reg;
    logic signed [GAIN_W-1:0] gain_cur_reg;
    logic signed [GAIN_W-1:0] gain_prev_reg;

    // history
    logic signed [ERR_W-1:0]  prev_error_reg, prev_error_next;
    logic [DRIVE_W-1:0]       prev_drive_reg, prev_drive_next;

    // pipeline stages
    logic                     in_valid_reg;
    logic                     in_mode_reg;
    logic signed [TEMP_W-1:0] in_temp_reg;
    logic                     mid_valid_reg;
    logic [DRIVE_W-1:0]       mid_drive_reg, mid_drive_next;
    logic                     mid_clamped_reg, mid_clamped_next;
    logic                     m_valid_reg;
    logic [DRIVE_W-1:0]       m_drive_reg;
    logic [DUTY_W-1:0]        m_duty_reg, m_duty_next;
    logic                     m_clamped_reg;

    logic out_en, mid_en, in_en;

    // datapath signals
    logic signed [ERR_W-1:0]  err;
    logic signed [PROD_W-1:0] prod_cur, prod_prev;
    logic signed [TERM_W-1:0] term_cur, term_prev;
    logic signed [RAW_W-1:0]  raw;
    logic [DUTY_X_W-1:0]      duty_x;
    logic [DUTY_PROD_W-1:0]   duty_prod;

    // stage advance: a stage moves when the next one is empty or moving
    assign out_en   = !m_valid_reg || m_tready;
    assign mid_en   = !mid_valid_reg || out_en;
    assign in_en    = !in_valid_reg || mid_en;
    assign s_tready = in_en;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg  <= SETPOINT_RESET;
            gain_cur_reg  <= GAIN_CUR_RESET;
            gain_prev_reg <= GAIN_PREV_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SETPOINT:  setpoint_reg  <= $signed(cfg_data[TEMP_W-1:0]);
                CFG_GAIN_CUR:  gain_cur_reg  <= $signed(cfg_data[GAIN_W-1:0]);
                CFG_GAIN_PREV: gain_prev_reg <= $signed(cfg_data[GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en && s_tvalid) begin
            in_mode_reg <= s_tuser[0];
            in_temp_reg <= $signed(s_tdata[TEMP_W-1:0]);
        end
    end

    // error and gain products, floor shift is taking the upper bits
    assign err       = ERR_W'(setpoint_reg) - ERR_W'(in_temp_reg);
    assign prod_cur  = PROD_W'(gain_cur_reg) * PROD_W'(err);
    assign prod_prev = PROD_W'(gain_prev_reg) * PROD_W'(prev_error_reg);
    assign term_cur  = prod_cur[PROD_W-1:PRODUCT_SHIFT];
    assign term_prev = prod_prev[PROD_W-1:PRODUCT_SHIFT];

    // raw drive sum
    assign raw = {{2{term_cur[TERM_W-1]}}, term_cur}
               + {{2{term_prev[TERM_W-1]}}, term_prev}
               + $signed({{(RAW_W-DRIVE_W){1'b0}}, prev_drive_reg});

    // clamp and clear
    always_comb begin
        mid_drive_next   = raw[DRIVE_W-1:0];
        mid_clamped_next = 1'b0;
        prev_error_next  = err;
        if (in_mode_reg == MODE_CLEAR) begin
            mid_drive_next  = '0;
            prev_error_next = '0;
        end else if (raw > $signed({{(RAW_W-DRIVE_W){1'b0}}, DRIVE_MAX})) begin
            mid_drive_next   = DRIVE_MAX;
            mid_clamped_next = 1'b1;
        end else if (raw < 0) begin
            mid_drive_next   = '0;
            mid_clamped_next = 1'b1;
        end
        prev_drive_next = mid_drive_next;
    end

    // middle stage and history update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg  <= 1'b0;
            prev_error_reg <= '0;
            prev_drive_reg <= '0;
        end else if (mid_en) begin
            mid_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                prev_error_reg <= prev_error_next;
                prev_drive_reg <= prev_drive_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_en && in_valid_reg) begin
            mid_drive_reg   <= mid_drive_next;
            mid_clamped_reg <= mid_clamped_next;
        end
    end

    // duty = floor(4*drive/3) by reciprocal multiply
    assign duty_x      = {mid_drive_reg, 2'b00};
    assign duty_prod   = DUTY_PROD_W'(duty_x) * DUTY_PROD_W'(DUTY_RECIP);
    assign m_duty_next = duty_prod[DUTY_SHIFT +: DUTY_W];

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && mid_valid_reg) begin
            m_drive_reg   <= mid_drive_reg;
            m_duty_reg    <= m_duty_next;
            m_clamped_reg <= mid_clamped_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_duty_reg, m_drive_reg};
    assign m_tuser  = m_clamped_reg;

`ifndef SYNTHESIS
    // drive never leaves the 0..12 V range
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_drive_reg <= DRIVE_MAX))
        else $error("drive above limit");

    // full drive gives full duty
    a_full_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_drive_reg == DRIVE_MAX) |-> (m_duty_reg == 17'd65536))
        else $error("duty wrong at full drive");

    // a clear request wipes the history
    a_clear_history: assert property (@(posedge aclk) disable iff (!aresetn)
        (mid_en && in_valid_reg && in_mode_reg == MODE_CLEAR)
        |=> (prev_error_reg == '0 && prev_drive_reg == '0))
        else $error("history not cleared");

    // input only stalls when every stage is full
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && mid_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled with room in pipeline");
`endif

endmodule
